// ===== rtl/yolc_pkg.sv =====
// Shared types, constants and helper functions for the object-file line checker.
// Depends on nothing; every other file of the block imports it.
package yolc_pkg;

  // Layout of a line and limits of the target memory.
  localparam int MEM_SIZE    = 4096;
  localparam int BAR_COLUMN  = 28;
  localparam int DATA_COLUMN = 7;
  localparam int MAX_BYTES   = 10;

  // Widths of the per-line state.
  localparam int COL_W   = 6;
  localparam int ADDR_W  = 12;
  localparam int NFA_W   = 13;
  localparam int DIGIT_W = 5;
  localparam int NB_W    = 4;
  localparam int LINE_W  = 16;

  localparam logic [COL_W-1:0]   COL_MAX    = {COL_W{1'b1}};
  localparam logic [COL_W-1:0]   COL_BAR    = COL_W'(BAR_COLUMN);
  localparam logic [COL_W-1:0]   COL_DATA   = COL_W'(DATA_COLUMN);
  localparam logic [LINE_W-1:0]  LINE_MAX   = {LINE_W{1'b1}};
  localparam logic [NFA_W-1:0]   MEM_LIMIT  = NFA_W'(MEM_SIZE);
  localparam logic [DIGIT_W-1:0] DIGIT_MAX  = DIGIT_W'(2 * MAX_BYTES);

  // Characters that the fixed columns expect.
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_BAR   = 8'h7C;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_WRITE  = 2'd0,
    KIND_ACCEPT = 2'd1,
    KIND_REJECT = 2'd2
  } kind_t;

  // One finished line, handed from the front part to the back part.
  typedef struct packed {
    logic                            ok;
    logic [NB_W-1:0]                 nbytes;
    logic [ADDR_W-1:0]               addr;
    logic [LINE_W-1:0]               line;
    logic [MAX_BYTES-1:0][7:0]       bytes;
  } job_t;

  // Head of the line queue as the back part sees it.
  typedef struct packed {
    logic valid;
    job_t job;
  } head_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } hex_t;

  // Decodes one ASCII hex digit in either case.
  function automatic hex_t hex_digit(input logic [7:0] c);
    hex_t h;
    h.valid = 1'b1;
    h.value = 4'h0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.value = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.value = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.value = 4'(c - 8'h37);
    end else begin
      h.valid = 1'b0;
    end
    return h;
  endfunction

endpackage

// ===== rtl/yolc_front.sv =====
// Front part: accepts characters, checks each column and buffers data bytes.
// At line end it classifies the line and hands a job to the queue. Uses yolc_pkg.
module yolc_front
  import yolc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] char_code,
  input  logic       line_end,
  output logic       push,
  output job_t       push_job
);

  logic [COL_W-1:0]   column;
  logic [LINE_W-1:0]  line_count;
  logic [ADDR_W-1:0]  line_address;
  logic [NFA_W-1:0]   next_free_address;
  logic [DIGIT_W-1:0] digit_count;
  logic               data_ended;
  logic               blank_line_mode;
  logic               line_bad;
  logic               halted;
  logic [MAX_BYTES-1:0][7:0] byte_buffer;

  logic [ADDR_W-1:0]  line_address_next;
  logic [DIGIT_W-1:0] digit_count_next;
  logic               data_ended_next;
  logic               blank_line_mode_next;
  logic               line_bad_next;
  logic               buf_we;
  hex_t               hex;
  logic [NB_W-1:0]    slot;
  logic [NB_W-1:0]    nbytes;
  logic [NFA_W-1:0]   line_top;
  logic               ok;
  logic               step;

  assign hex  = hex_digit(char_code);
  assign slot = digit_count[DIGIT_W-1:1];
  assign step = accept && !halted;

  // Column check of the current character.
  always_comb begin
    line_address_next    = line_address;
    digit_count_next     = digit_count;
    data_ended_next      = data_ended;
    blank_line_mode_next = blank_line_mode;
    line_bad_next        = line_bad;
    buf_we               = 1'b0;
    priority if (column > COL_BAR) begin
      // Characters past the bar are not checked.
    end else if (column == COL_BAR) begin
      if (char_code != CH_BAR) line_bad_next = 1'b1;
    end else if (column == '0) begin
      if (char_code == CH_SPACE) blank_line_mode_next = 1'b1;
      else if (char_code != CH_ZERO) line_bad_next = 1'b1;
    end else if (blank_line_mode) begin
      if (char_code != CH_SPACE) line_bad_next = 1'b1;
    end else if (column == COL_W'(1)) begin
      if (char_code != CH_X) line_bad_next = 1'b1;
    end else if (column <= COL_W'(4)) begin
      if (!hex.valid) line_bad_next = 1'b1;
      else line_address_next = {line_address[ADDR_W-5:0], hex.value};
    end else if (column == COL_W'(5)) begin
      if (char_code != CH_COLON) line_bad_next = 1'b1;
    end else if (column < COL_DATA) begin
      if (char_code != CH_SPACE) line_bad_next = 1'b1;
    end else if (data_ended) begin
      if (char_code != CH_SPACE) line_bad_next = 1'b1;
    end else if (char_code == CH_SPACE) begin
      data_ended_next = 1'b1;
    end else if (!hex.valid || digit_count >= DIGIT_MAX) begin
      line_bad_next = 1'b1;
    end else begin
      buf_we           = 1'b1;
      digit_count_next = digit_count + DIGIT_W'(1);
    end
  end

  // Verdict on the line, taken when its last character arrives.
  assign nbytes   = digit_count[DIGIT_W-1:1];
  assign line_top = {1'b0, line_address} + NFA_W'(nbytes);
  assign ok = !line_bad_next && (column >= COL_BAR) &&
              (blank_line_mode_next ||
               (!digit_count[0] && ({1'b0, line_address} >= next_free_address) &&
                (line_top <= MEM_LIMIT)));

  assign push            = step && line_end;
  assign push_job.ok     = ok;
  assign push_job.nbytes = (ok && !blank_line_mode_next) ? nbytes : '0;
  assign push_job.addr   = line_address;
  assign push_job.line   = line_count;
  assign push_job.bytes  = byte_buffer;

  // Per-line and per-file state.
  always_ff @(posedge clk) begin
    if (rst) begin
      column            <= '0;
      line_count        <= LINE_W'(1);
      line_address      <= '0;
      next_free_address <= '0;
      digit_count       <= '0;
      data_ended        <= 1'b0;
      blank_line_mode   <= 1'b0;
      line_bad          <= 1'b0;
      halted            <= 1'b0;
    end else if (step) begin
      if (!line_end) begin
        if (column != COL_MAX) column <= column + COL_W'(1);
        line_address    <= line_address_next;
        digit_count     <= digit_count_next;
        data_ended      <= data_ended_next;
        blank_line_mode <= blank_line_mode_next;
        line_bad        <= line_bad_next;
      end else begin
        column          <= '0;
        line_address    <= '0;
        digit_count     <= '0;
        data_ended      <= 1'b0;
        blank_line_mode <= 1'b0;
        line_bad        <= 1'b0;
        if (ok) begin
          if (line_count != LINE_MAX) line_count <= line_count + LINE_W'(1);
          if (!blank_line_mode_next && nbytes != '0) next_free_address <= line_top;
        end else begin
          halted <= 1'b1;
        end
      end
    end
  end

  // Byte buffer: high nibble on an even digit, low nibble on an odd one.
  always_ff @(posedge clk) begin
    if (step && buf_we) begin
      if (!digit_count[0]) byte_buffer[slot] <= {hex.value, 4'h0};
      else byte_buffer[slot][3:0] <= hex.value;
    end
  end

endmodule

// ===== rtl/yolc_queue.sv =====
// Two-entry queue of finished lines between the front and the back part.
// Uses job_t and head_t from yolc_pkg.
module yolc_queue
  import yolc_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  job_t  push_job,
  input  logic  pop,
  output head_t head,
  output logic  full
);

  job_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full       = (count == 2'd2);
  assign head.valid = (count != 2'd0);
  assign head.job   = entries[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      if (push && !pop) count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_job;
  end

endmodule

// ===== rtl/yolc_back.sv =====
// Back part: turns each queued line into its byte writes and closing status.
// Drives the registered result channel. Uses yolc_pkg.
module yolc_back
  import yolc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  head_t              head,
  output logic               pop,
  input  logic               result_stall,
  output logic               result_valid,
  output logic [1:0]         kind,
  output logic [ADDR_W-1:0]  write_address,
  output logic [7:0]         write_byte,
  output logic [LINE_W-1:0]  line_number,
  output logic               last_of_run
);

  logic [NB_W-1:0] index;
  logic            load;
  logic            is_write;

  assign load     = head.valid && (!result_valid || !result_stall);
  assign is_write = (index < head.job.nbytes);
  assign pop      = load && !is_write;

  // Byte counter within the current line.
  always_ff @(posedge clk) begin
    if (rst) begin
      index        <= '0;
      result_valid <= 1'b0;
    end else begin
      if (load) begin
        index <= is_write ? index + NB_W'(1) : '0;
      end
      if (load) result_valid <= 1'b1;
      else if (!result_stall) result_valid <= 1'b0;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (load) begin
      line_number <= head.job.line;
      if (is_write) begin
        kind          <= KIND_WRITE;
        write_address <= head.job.addr + ADDR_W'(index);
        write_byte    <= head.job.bytes[index];
        last_of_run   <= 1'b0;
      end else begin
        kind          <= head.job.ok ? KIND_ACCEPT : KIND_REJECT;
        write_address <= '0;
        write_byte    <= '0;
        last_of_run   <= 1'b1;
      end
    end
  end

endmodule

// ===== rtl/yo_line_check_and_load_core.sv =====
// Top level of the object-file line checker and loader.
// Instantiates yolc_front, yolc_queue and yolc_back; uses yolc_pkg.
//
// Usage:
//   The character channel (char_valid, char_stall, char_code, line_end) takes
//   one text character per cycle; line_end marks the last character of a line.
//   Each line is checked column by column as it arrives. When its last
//   character is taken, the line goes into a two-entry queue, and the result
//   channel (result_valid, result_stall and the payload) then gives one item
//   per cycle: the line's byte writes in rising address order, then one status
//   item with last_of_run set.
//   Throughput is one character per cycle while char_stall is low. A line
//   enters the queue when its last character is taken; its first result then
//   passes through the output register of the back part. A line with n bytes
//   gives n + 1 result items. The limit is the single output register of the
//   back part, one item per cycle while result_stall is low.
//   char_stall rises only while both queue entries hold lines not yet fully
//   sent, so a receiver that stalls for long enough stops the input too.
//   After a rejected line all further characters are taken and dropped.
//   A synchronous reset clears the line state, sets the line number to one and
//   empties the queue; no result is pending after it.
module yo_line_check_and_load_core
  import yolc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               char_valid,
  output logic               char_stall,
  input  logic [7:0]         char_code,
  input  logic               line_end,
  output logic               result_valid,
  input  logic               result_stall,
  output logic [1:0]         kind,
  output logic [ADDR_W-1:0]  write_address,
  output logic [7:0]         write_byte,
  output logic [LINE_W-1:0]  line_number,
  output logic               last_of_run
);

  logic  push;
  job_t  push_job;
  logic  pop;
  logic  full;
  head_t head;

  assign char_stall = full;

  // Checking front part.
  yolc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (char_valid && !char_stall),
    .char_code (char_code),
    .line_end  (line_end),
    .push      (push),
    .push_job  (push_job)
  );

  // Queue of finished lines.
  yolc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .full     (full)
  );

  // Result sequencing back part.
  yolc_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .pop           (pop),
    .result_stall  (result_stall),
    .result_valid  (result_valid),
    .kind          (kind),
    .write_address (write_address),
    .write_byte    (write_byte),
    .line_number   (line_number),
    .last_of_run   (last_of_run)
  );

endmodule

// ===== rtl/yolc_checker.sv =====
// Port-level checks of the line checker over time, bound to the top level.
// Uses kind_t codes from yolc_pkg.
module yolc_checker
  import yolc_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               char_valid,
  input logic               char_stall,
  input logic [7:0]         char_code,
  input logic               line_end,
  input logic               result_valid,
  input logic               result_stall,
  input logic [1:0]         kind,
  input logic [ADDR_W-1:0]  write_address,
  input logic [7:0]         write_byte,
  input logic [LINE_W-1:0]  line_number,
  input logic               last_of_run
);

  // A status item, and only a status item, closes a run.
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (last_of_run == (kind != KIND_WRITE)))
    else $error("last_of_run does not match the item kind");

  // Only the three defined kinds appear.
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (kind == KIND_WRITE || kind == KIND_ACCEPT || kind == KIND_REJECT))
    else $error("undefined result kind");

  // Nothing follows a rejected line.
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_stall && kind == KIND_REJECT) |=> !result_valid)
    else $error("result after a rejected line");

  // A stalled result item holds.
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=>
      (result_valid && $stable(kind) && $stable(write_address) &&
       $stable(write_byte) && $stable(line_number)))
    else $error("stalled result item changed");

  // Reset leaves no result pending and the input open.
  assert property (@(posedge clk) rst |=> (!result_valid && !char_stall))
    else $error("state after reset");

endmodule

bind yo_line_check_and_load_core yolc_checker u_checker (.*);
